// ===== rtl/core/note_voice_allocator_macros.svh =====
// Assertion macros used by the checker of the voice allocator.
`ifndef NOTE_VOICE_ALLOCATOR_MACROS_SVH
`define NOTE_VOICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NVA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("voice allocator check failed");

// Next-cycle implication, disabled during reset.
`define NVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("voice allocator check failed");

`endif

// ===== rtl/core/nva_pkg.sv =====
`default_nettype none

package nva_pkg;

    localparam int NUM_DRIVES = 4;
    localparam int HOLD_DEPTH = 3;

    localparam int NOTE_W  = 7;
    localparam int MASK_W  = 4;
    localparam int IDX_W   = 2;
    localparam int DRV_W   = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
    localparam int CNT_W   = $clog2(HOLD_DEPTH + 1);
    localparam int HIDX_W  = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

    localparam logic              CMD_PLAY  = 1'b0;
    localparam logic              CMD_STOP  = 1'b1;
    localparam logic [NOTE_W-1:0] KILL_NOTE = '0;

    localparam logic [DRV_W-1:0] LAST_DRV  = DRV_W'(NUM_DRIVES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(HOLD_DEPTH);

    typedef logic [DRV_W-1:0]                  t_drv;
    typedef logic [CNT_W-1:0]                  t_cnt;
    typedef logic [NOTE_W-1:0]                 t_note;
    typedef logic [HOLD_DEPTH-1:0][NOTE_W-1:0] t_row;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PURGE,
        S_APPLY,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_PLAY,
        OP_KILL,
        OP_STOP,
        OP_PURGE
    } t_op;

    typedef struct packed {
        t_op   op;
        t_note note;
        logic  sel;
        logic  busy;
        t_note vnote;
        t_cnt  cnt;
        t_row  row;
        t_cnt  best;
        logic  found;
    } t_unit_in;

    typedef struct packed {
        logic take;
        logic stop;
        logic clear;
        t_cnt best;
        logic purge;
        t_row row;
    } t_unit_out;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  drive_index;
        t_note             drive_note;
        logic              drive_active;
        logic              restart_now;
        logic [MASK_W-1:0] playing_mask;
    } t_result;

    function automatic logic [IDX_W-1:0] to_idx(input t_drv d);
        logic [DRV_W+IDX_W-1:0] w;
        w = {{IDX_W{1'b0}}, d};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [NUM_DRIVES-1:0] ext_mask(input logic [MASK_W-1:0] m);
        logic [MASK_W+NUM_DRIVES-1:0] w;
        w = {{NUM_DRIVES{1'b0}}, m};
        return w[NUM_DRIVES-1:0];
    endfunction

    function automatic logic [MASK_W-1:0] to_pmask(input logic [NUM_DRIVES-1:0] b);
        logic [MASK_W+NUM_DRIVES-1:0] w;
        w = {{MASK_W{1'b0}}, b};
        return w[MASK_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nva_in_if.sv =====
`default_nettype none

interface nva_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [nva_pkg::NOTE_W-1:0] note;
    logic [nva_pkg::MASK_W-1:0] drive_mask;

    modport source (output valid, output cmd, output note, output drive_mask, input ready);
    modport sink   (input valid, input cmd, input note, input drive_mask, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nva_out_if.sv =====
`default_nettype none

interface nva_out_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [nva_pkg::IDX_W-1:0]  drive_index;
    logic [nva_pkg::NOTE_W-1:0] drive_note;
    logic                       drive_active;
    logic                       restart_now;
    logic [nva_pkg::MASK_W-1:0] playing_mask;

    modport source (
        output valid, output hit, output drive_index, output drive_note,
        output drive_active, output restart_now, output playing_mask, input ready
    );
    modport sink (
        input valid, input hit, input drive_index, input drive_note,
        input drive_active, input restart_now, input playing_mask, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/nva_unit.sv =====
`default_nettype none

module nva_unit (
    input  nva_pkg::t_unit_in  i_req,
    output nva_pkg::t_unit_out o_rsp
);

    logic                       rm_hit;
    logic [nva_pkg::HIDX_W-1:0] rm_pos;

    always_comb begin
        rm_hit = 1'b0;
        rm_pos = '0;
        for (int k = 0; k < nva_pkg::HOLD_DEPTH; k++) begin
            if (!rm_hit && (nva_pkg::CNT_W'(k) < i_req.cnt) && (i_req.row[k] == i_req.note)) begin
                rm_hit = 1'b1;
                rm_pos = nva_pkg::HIDX_W'(k);
            end
        end

        o_rsp      = '0;
        o_rsp.best = i_req.best;
        o_rsp.row  = i_req.row;
        for (int k = 0; k < nva_pkg::HOLD_DEPTH - 1; k++) begin
            if (nva_pkg::HIDX_W'(k) >= rm_pos) begin
                o_rsp.row[k] = i_req.row[k+1];
            end
        end

        unique case (i_req.op)
            nva_pkg::OP_PLAY: begin
                if (i_req.sel && !i_req.busy) begin
                    o_rsp.take = 1'b1;
                    o_rsp.stop = 1'b1;
                    o_rsp.best = '0;
                end else if (i_req.sel && (i_req.cnt < i_req.best)) begin
                    o_rsp.take = 1'b1;
                    o_rsp.best = i_req.cnt;
                end
            end
            nva_pkg::OP_KILL: begin
                o_rsp.take  = i_req.sel && i_req.busy && !i_req.found;
                o_rsp.clear = i_req.sel;
            end
            nva_pkg::OP_STOP: begin
                o_rsp.take = i_req.sel && i_req.busy && (i_req.vnote == i_req.note);
                o_rsp.stop = o_rsp.take;
            end
            nva_pkg::OP_PURGE: begin
                o_rsp.purge = i_req.sel && rm_hit;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/note_voice_allocator.sv =====
// Channel | Dir | Payload                                   | Transfer
// i_in    | in  | cmd, note, drive_mask                     | valid && ready
// o_out   | out | hit, drive_index, drive_note,             | valid && ready
//         |     | drive_active, restart_now, playing_mask   |
// The time from one transfer to the next possible transfer is set by the shared compare
// unit, which looks at one drive per cycle in the scan and purge passes; only an unmatched
// note-off runs the purge pass as well as the scan pass.
// Reset: synchronous, active low; clears all drives to idle with empty stacks.
// A result waiting on a stalled o_out does not block the next i_in transfer; the block
// holds in its last step only when a second result is ready before the first is taken.
`default_nettype none

module note_voice_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    nva_in_if.sink           i_in,
    nva_out_if.source        o_out
);

    nva_pkg::t_state r_state, n_state;
    nva_pkg::t_op    r_op, n_op;
    nva_pkg::t_note  r_note, n_note;
    logic [nva_pkg::NUM_DRIVES-1:0] r_mask, n_mask;
    nva_pkg::t_drv   r_idx, n_idx;
    nva_pkg::t_drv   r_pick, n_pick;
    logic            r_found, n_found;
    nva_pkg::t_cnt   r_best, n_best;
    nva_pkg::t_result r_res, n_res;
    nva_pkg::t_result r_out, n_out;
    logic            r_ov, n_ov;

    logic [nva_pkg::NUM_DRIVES-1:0] r_busy, n_busy;
    nva_pkg::t_note r_vnote [nva_pkg::NUM_DRIVES];
    nva_pkg::t_note n_vnote [nva_pkg::NUM_DRIVES];
    nva_pkg::t_row  r_held  [nva_pkg::NUM_DRIVES];
    nva_pkg::t_row  n_held  [nva_pkg::NUM_DRIVES];
    nva_pkg::t_cnt  r_cnt   [nva_pkg::NUM_DRIVES];
    nva_pkg::t_cnt  n_cnt   [nva_pkg::NUM_DRIVES];

    nva_pkg::t_unit_in  unit_in;
    nva_pkg::t_unit_out unit_out;

    nva_unit u_unit (
        .i_req (unit_in),
        .o_rsp (unit_out)
    );

    always_comb begin
        unit_in.op    = r_op;
        unit_in.note  = r_note;
        unit_in.sel   = r_mask[r_idx];
        unit_in.busy  = r_busy[r_idx];
        unit_in.vnote = r_vnote[r_idx];
        unit_in.cnt   = r_cnt[r_idx];
        unit_in.row   = r_held[r_idx];
        unit_in.best  = r_best;
        unit_in.found = r_found;
    end

    assign i_in.ready         = (r_state == nva_pkg::S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.hit          = r_out.hit;
    assign o_out.drive_index  = r_out.drive_index;
    assign o_out.drive_note   = r_out.drive_note;
    assign o_out.drive_active = r_out.drive_active;
    assign o_out.restart_now  = r_out.restart_now;
    assign o_out.playing_mask = r_out.playing_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nva_pkg::S_IDLE;
            r_op    <= nva_pkg::OP_PLAY;
            r_ov    <= 1'b0;
            r_busy  <= '0;
            for (int d = 0; d < nva_pkg::NUM_DRIVES; d++) begin
                r_cnt[d] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_ov    <= n_ov;
            r_busy  <= n_busy;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_note  <= n_note;
        r_mask  <= n_mask;
        r_idx   <= n_idx;
        r_pick  <= n_pick;
        r_found <= n_found;
        r_best  <= n_best;
        r_res   <= n_res;
        r_out   <= n_out;
        r_vnote <= n_vnote;
        r_held  <= n_held;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_note  = r_note;
        n_mask  = r_mask;
        n_idx   = r_idx;
        n_pick  = r_pick;
        n_found = r_found;
        n_best  = r_best;
        n_res   = r_res;
        n_out   = r_out;
        n_busy  = r_busy;
        n_vnote = r_vnote;
        n_held  = r_held;
        n_cnt   = r_cnt;
        n_ov    = r_ov && !o_out.ready;

        unique case (r_state)
            nva_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_note  = i_in.note;
                    n_mask  = nva_pkg::ext_mask(i_in.drive_mask);
                    n_idx   = '0;
                    n_pick  = '0;
                    n_found = 1'b0;
                    n_best  = nva_pkg::FULL_CNT;
                    n_res   = '0;
                    n_state = nva_pkg::S_SCAN;
                    priority if (i_in.cmd == nva_pkg::CMD_PLAY) begin
                        n_op = nva_pkg::OP_PLAY;
                    end else if (i_in.note == nva_pkg::KILL_NOTE) begin
                        n_op = nva_pkg::OP_KILL;
                    end else begin
                        n_op = nva_pkg::OP_STOP;
                    end
                end
            end

            nva_pkg::S_SCAN: begin
                n_best = unit_out.best;
                if (unit_out.take) begin
                    n_found = 1'b1;
                    n_pick  = r_idx;
                    if (r_op == nva_pkg::OP_KILL) begin
                        n_res.hit         = 1'b1;
                        n_res.drive_index = nva_pkg::to_idx(r_idx);
                    end
                end
                if (unit_out.clear) begin
                    n_busy[r_idx] = 1'b0;
                    n_cnt[r_idx]  = '0;
                end
                priority if (unit_out.stop) begin
                    n_state = nva_pkg::S_APPLY;
                end else if (r_idx == nva_pkg::LAST_DRV) begin
                    priority if (r_op == nva_pkg::OP_PLAY) begin
                        n_state = nva_pkg::S_APPLY;
                    end else if (r_op == nva_pkg::OP_STOP) begin
                        n_op    = nva_pkg::OP_PURGE;
                        n_idx   = '0;
                        n_state = nva_pkg::S_PURGE;
                    end else begin
                        n_state = nva_pkg::S_DONE;
                    end
                end else begin
                    n_idx = r_idx + nva_pkg::DRV_W'(1);
                end
            end

            nva_pkg::S_PURGE: begin
                if (unit_out.purge) begin
                    n_held[r_idx] = unit_out.row;
                    n_cnt[r_idx]  = r_cnt[r_idx] - nva_pkg::CNT_W'(1);
                end
                if (r_idx == nva_pkg::LAST_DRV) begin
                    n_state = nva_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + nva_pkg::DRV_W'(1);
                end
            end

            nva_pkg::S_APPLY: begin
                n_state = nva_pkg::S_DONE;
                if (r_op == nva_pkg::OP_PLAY) begin
                    if (r_found && (r_best < nva_pkg::FULL_CNT)) begin
                        if (r_busy[r_pick]) begin
                            n_held[r_pick][0] = r_vnote[r_pick];
                            for (int k = 1; k < nva_pkg::HOLD_DEPTH; k++) begin
                                n_held[r_pick][k] = r_held[r_pick][k-1];
                            end
                            n_cnt[r_pick] = r_cnt[r_pick] + nva_pkg::CNT_W'(1);
                        end else begin
                            n_res.restart_now = 1'b1;
                        end
                        n_busy[r_pick]     = 1'b1;
                        n_vnote[r_pick]    = r_note;
                        n_res.hit          = 1'b1;
                        n_res.drive_index  = nva_pkg::to_idx(r_pick);
                        n_res.drive_note   = r_note;
                        n_res.drive_active = 1'b1;
                    end
                end else begin
                    n_res.hit         = 1'b1;
                    n_res.drive_index = nva_pkg::to_idx(r_pick);
                    if (r_cnt[r_pick] != '0) begin
                        n_vnote[r_pick] = r_held[r_pick][0];
                        for (int k = 0; k < nva_pkg::HOLD_DEPTH - 1; k++) begin
                            n_held[r_pick][k] = r_held[r_pick][k+1];
                        end
                        n_cnt[r_pick]      = r_cnt[r_pick] - nva_pkg::CNT_W'(1);
                        n_res.drive_note   = r_held[r_pick][0];
                        n_res.drive_active = 1'b1;
                    end else begin
                        n_busy[r_pick] = 1'b0;
                    end
                end
            end

            nva_pkg::S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_out              = r_res;
                    n_out.playing_mask = nva_pkg::to_pmask(r_busy);
                    n_ov               = 1'b1;
                    n_state            = nva_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = nva_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/nva_chk.sv =====
`default_nettype none

`include "note_voice_allocator_macros.svh"

module nva_chk (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       i_ready,
    input wire logic                       i_hit,
    input wire logic [nva_pkg::IDX_W-1:0]  i_drive_index,
    input wire logic [nva_pkg::NOTE_W-1:0] i_drive_note,
    input wire logic                       i_drive_active,
    input wire logic                       i_restart_now,
    input wire logic [nva_pkg::MASK_W-1:0] i_playing_mask
);

    `NVA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_hit) && $stable(i_drive_index) && $stable(i_drive_note) && $stable(i_drive_active) && $stable(i_restart_now) && $stable(i_playing_mask))
    `NVA_ASSERT_NOW(a_miss_quiet, i_clk, i_rst_n, i_valid && !i_hit, (i_drive_index == '0) && (i_drive_note == '0) && !i_drive_active && !i_restart_now)
    `NVA_ASSERT_NOW(a_restart_plays, i_clk, i_rst_n, i_valid && i_restart_now, i_hit && i_drive_active)
    `NVA_ASSERT_NOW(a_led_matches, i_clk, i_rst_n, i_valid && i_hit, i_playing_mask[i_drive_index] == i_drive_active)
    `NVA_ASSERT_NOW(a_idle_silent, i_clk, i_rst_n, i_valid && i_hit && !i_drive_active, i_drive_note == '0)

endmodule

bind note_voice_allocator nva_chk u_nva_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_hit          (o_out.hit),
    .i_drive_index  (o_out.drive_index),
    .i_drive_note   (o_out.drive_note),
    .i_drive_active (o_out.drive_active),
    .i_restart_now  (o_out.restart_now),
    .i_playing_mask (o_out.playing_mask)
);

`default_nettype wire

// ===== tb/note_voice_allocator_tb.sv =====
`default_nettype none

module note_voice_allocator_tb;

    logic i_clk;
    logic i_rst_n;

    nva_in_if  in_if();
    nva_out_if out_if();

    note_voice_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic           voice_busy [nva_pkg::NUM_DRIVES];
    nva_pkg::t_note voice_note [nva_pkg::NUM_DRIVES];
    nva_pkg::t_note held_notes [nva_pkg::NUM_DRIVES][nva_pkg::HOLD_DEPTH];
    int             held_count [nva_pkg::NUM_DRIVES];

    nva_pkg::t_result pending_results[$];
    nva_pkg::t_result due;
    int               mismatches;
    int               idle_pct;
    int               stall_pct;
    nva_pkg::t_note   note_pool[6];

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #2_000_000;
        $display("note_voice_allocator_tb NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic nva_pkg::t_result allocate_voice(input logic op,
                                                        input nva_pkg::t_note nt,
                                                        input logic [nva_pkg::MASK_W-1:0] msk);
        nva_pkg::t_result r;
        int      pick;
        int      best;
        int      d;
        int      j;
        int      k;
        logic    done;
        r    = '0;
        pick = -1;
        best = nva_pkg::HOLD_DEPTH;
        done = 1'b0;
        if (op == nva_pkg::CMD_PLAY) begin
            for (d = 0; d < nva_pkg::NUM_DRIVES; d++) begin
                if (!done && d < nva_pkg::MASK_W && msk[d]) begin
                    if (!voice_busy[d]) begin
                        pick = d;
                        best = 0;
                        done = 1'b1;
                    end else if (held_count[d] < best) begin
                        best = held_count[d];
                        pick = d;
                    end
                end
            end
            if (pick >= 0 && best < nva_pkg::HOLD_DEPTH) begin
                if (voice_busy[pick]) begin
                    for (k = held_count[pick]; k > 0; k--)
                        held_notes[pick][k] = held_notes[pick][k-1];
                    held_notes[pick][0] = voice_note[pick];
                    held_count[pick]++;
                end else begin
                    r.restart_now = 1'b1;
                end
                voice_busy[pick]   = 1'b1;
                voice_note[pick]   = nt;
                r.hit              = 1'b1;
                r.drive_index      = nva_pkg::IDX_W'(pick);
                r.drive_note       = nt;
                r.drive_active     = 1'b1;
            end
        end else if (nt == nva_pkg::KILL_NOTE) begin
            for (d = 0; d < nva_pkg::NUM_DRIVES; d++) begin
                if (d < nva_pkg::MASK_W && msk[d]) begin
                    if (voice_busy[d] && !r.hit) begin
                        r.hit         = 1'b1;
                        r.drive_index = nva_pkg::IDX_W'(d);
                    end
                    voice_busy[d] = 1'b0;
                    held_count[d] = 0;
                end
            end
        end else begin
            for (d = 0; d < nva_pkg::NUM_DRIVES; d++) begin
                if (!r.hit && d < nva_pkg::MASK_W && msk[d] && voice_busy[d] &&
                    voice_note[d] == nt) begin
                    r.hit         = 1'b1;
                    r.drive_index = nva_pkg::IDX_W'(d);
                    if (held_count[d] > 0) begin
                        voice_note[d] = held_notes[d][0];
                        for (j = 0; j < held_count[d] - 1; j++)
                            held_notes[d][j] = held_notes[d][j+1];
                        held_count[d]--;
                        r.drive_note   = voice_note[d];
                        r.drive_active = 1'b1;
                    end else begin
                        voice_busy[d] = 1'b0;
                    end
                end
            end
            if (!r.hit) begin
                for (d = 0; d < nva_pkg::NUM_DRIVES; d++) begin
                    done = 1'b0;
                    if (d < nva_pkg::MASK_W && msk[d]) begin
                        for (j = 0; j < held_count[d]; j++) begin
                            if (!done && held_notes[d][j] == nt) begin
                                for (k = j; k + 1 < held_count[d]; k++)
                                    held_notes[d][k] = held_notes[d][k+1];
                                done = 1'b1;
                            end
                        end
                        if (done)
                            held_count[d]--;
                    end
                end
            end
        end
        for (d = 0; d < nva_pkg::NUM_DRIVES && d < nva_pkg::MASK_W; d++)
            r.playing_mask[d] = voice_busy[d];
        return r;
    endfunction

    task automatic send_event(input logic op, input nva_pkg::t_note nt,
                              input logic [nva_pkg::MASK_W-1:0] msk);
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.cmd        <= op;
        in_if.note       <= nt;
        in_if.drive_mask <= msk;
        do
            @(posedge i_clk);
        while (!(in_if.valid && in_if.ready));
        pending_results.push_back(allocate_voice(op, nt, msk));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending");
                mismatches++;
            end else begin
                due = pending_results.pop_front();
                if (out_if.hit !== due.hit) begin
                    $error("hit: expected %0d, actual %0d", due.hit, out_if.hit);
                    mismatches++;
                end
                if (out_if.drive_index !== due.drive_index) begin
                    $error("drive_index: expected %0d, actual %0d",
                           due.drive_index, out_if.drive_index);
                    mismatches++;
                end
                if (out_if.drive_note !== due.drive_note) begin
                    $error("drive_note: expected %0d, actual %0d",
                           due.drive_note, out_if.drive_note);
                    mismatches++;
                end
                if (out_if.drive_active !== due.drive_active) begin
                    $error("drive_active: expected %0d, actual %0d",
                           due.drive_active, out_if.drive_active);
                    mismatches++;
                end
                if (out_if.restart_now !== due.restart_now) begin
                    $error("restart_now: expected %0d, actual %0d",
                           due.restart_now, out_if.restart_now);
                    mismatches++;
                end
                if (out_if.playing_mask !== due.playing_mask) begin
                    $error("playing_mask: expected %0h, actual %0h",
                           due.playing_mask, out_if.playing_mask);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_play_and_steal();
        send_event(nva_pkg::CMD_PLAY, 7'd127, 4'hF);
        send_event(nva_pkg::CMD_PLAY, 7'd1,   4'hF);
        send_event(nva_pkg::CMD_PLAY, 7'd64,  4'hF);
        send_event(nva_pkg::CMD_PLAY, 7'd85,  4'hF);
        send_event(nva_pkg::CMD_PLAY, 7'd5,   4'hF);
        send_event(nva_pkg::CMD_PLAY, 7'd6,   4'b0110);
        send_event(nva_pkg::CMD_PLAY, 7'd7,   4'b0001);
        send_event(nva_pkg::CMD_PLAY, 7'd8,   4'b0001);
        send_event(nva_pkg::CMD_PLAY, 7'd9,   4'b0001);
        send_event(nva_pkg::CMD_PLAY, 7'd10,  4'b0000);
    endtask

    task automatic test_release();
        send_event(nva_pkg::CMD_STOP, 7'd8,   4'hF);
        send_event(nva_pkg::CMD_STOP, 7'd64,  4'hF);
        send_event(nva_pkg::CMD_STOP, 7'd127, 4'hF);
        send_event(nva_pkg::CMD_STOP, 7'd99,  4'hF);
        send_event(nva_pkg::CMD_STOP, 7'd6,   4'b1000);
        send_event(nva_pkg::CMD_STOP, 7'd6,   4'hF);
    endtask

    task automatic test_kill();
        send_event(nva_pkg::CMD_STOP, nva_pkg::KILL_NOTE, 4'b0101);
        send_event(nva_pkg::CMD_STOP, nva_pkg::KILL_NOTE, 4'b0000);
        send_event(nva_pkg::CMD_PLAY, 7'd0,               4'b1000);
        send_event(nva_pkg::CMD_STOP, nva_pkg::KILL_NOTE, 4'hF);
        send_event(nva_pkg::CMD_STOP, nva_pkg::KILL_NOTE, 4'hF);
        send_event(nva_pkg::CMD_PLAY, 7'd127,             4'hF);
    endtask

    task automatic test_random_events(input int count, input int idle, input int stall);
        int   n;
        int   roll;
        logic op;
        nva_pkg::t_note nt;
        logic [nva_pkg::MASK_W-1:0] msk;
        idle_pct  = idle;
        stall_pct = stall;
        for (n = 0; n < 6; n++)
            note_pool[n] = nva_pkg::t_note'($urandom_range(1, 127));
        for (n = 0; n < count; n++) begin
            op   = ($urandom_range(99) < 55) ? nva_pkg::CMD_PLAY : nva_pkg::CMD_STOP;
            roll = $urandom_range(99);
            if (roll < 6)
                nt = nva_pkg::KILL_NOTE;
            else if (roll < 75)
                nt = note_pool[$urandom_range(5)];
            else
                nt = nva_pkg::t_note'($urandom_range(127));
            msk = ($urandom_range(99) < 60) ? {nva_pkg::MASK_W{1'b1}} :
                                              nva_pkg::MASK_W'($urandom_range(15));
            send_event(op, nt, msk);
        end
    endtask

    initial begin
        mismatches       = 0;
        idle_pct         = 0;
        stall_pct        = 0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.cmd        <= nva_pkg::CMD_PLAY;
        in_if.note       <= '0;
        in_if.drive_mask <= '0;
        for (int d = 0; d < nva_pkg::NUM_DRIVES; d++) begin
            voice_busy[d] = 1'b0;
            voice_note[d] = '0;
            held_count[d] = 0;
            for (int j = 0; j < nva_pkg::HOLD_DEPTH; j++)
                held_notes[d][j] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_play_and_steal();
        test_release();
        test_kill();
        test_random_events(170, 0, 0);
        test_random_events(170, 57, 0);
        test_random_events(170, 0, 57);
        test_random_events(170, 33, 33);
        in_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("note_voice_allocator_tb OK");
        else
            $display("note_voice_allocator_tb NOT OK");
        $finish;
    end
endmodule

`default_nettype wire

// ===== note_voice_allocator.f =====
+incdir+rtl/core
rtl/core/nva_pkg.sv
rtl/core/nva_in_if.sv
rtl/core/nva_out_if.sv
rtl/core/nva_unit.sv
rtl/core/note_voice_allocator.sv
rtl/core/nva_chk.sv
tb/note_voice_allocator_tb.sv
